/* hw/rtl/stk_pkg.sv */
`default_nettype none

package stk_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int PTR_W       = ADDR_W + 1;
  localparam int VAR_COUNT   = 26;
  localparam int VIDX_W      = 5;
  localparam int VAL_W       = 64;
  localparam int TAG_W       = 2;
  localparam int WORD_W      = VAL_W + TAG_W;
  localparam int OP_W        = 3;
  localparam int ST_W        = 2;

  // request codes
  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_DROP  = 3'd1;
  localparam logic [OP_W-1:0] OP_DUP   = 3'd2;
  localparam logic [OP_W-1:0] OP_SWAP  = 3'd3;
  localparam logic [OP_W-1:0] OP_ROT   = 3'd4;
  localparam logic [OP_W-1:0] OP_PICK  = 3'd5;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd6;
  localparam logic [OP_W-1:0] OP_STORE = 3'd7;

  // status codes
  localparam logic [ST_W-1:0] ST_OK  = 2'd0;
  localparam logic [ST_W-1:0] ST_OVF = 2'd1;
  localparam logic [ST_W-1:0] ST_UNF = 2'd2;

  // memory address select
  localparam logic [2:0] AS_SP   = 3'd0;
  localparam logic [2:0] AS_SP1  = 3'd1;
  localparam logic [2:0] AS_SP2  = 3'd2;
  localparam logic [2:0] AS_SP3  = 3'd3;
  localparam logic [2:0] AS_PICK = 3'd4;

  // memory write data select
  localparam logic [1:0] WD_NEW   = 2'd0;
  localparam logic [1:0] WD_TOS   = 2'd1;
  localparam logic [1:0] WD_RDATA = 2'd2;

  // top-of-stack register select
  localparam logic [1:0] TS_HOLD  = 2'd0;
  localparam logic [1:0] TS_NEW   = 2'd1;
  localparam logic [1:0] TS_RDATA = 2'd2;
  localparam logic [1:0] TS_A     = 2'd3;

  // stack pointer update
  localparam logic [1:0] SP_HOLD = 2'd0;
  localparam logic [1:0] SP_INC  = 2'd1;
  localparam logic [1:0] SP_DEC  = 2'd2;

  typedef struct packed {
    logic            req_ld;
    logic            mem_rd;
    logic            mem_wr;
    logic [2:0]      addr_sel;
    logic [1:0]      wd_sel;
    logic [1:0]      tos_sel;
    logic            a_ld;
    logic [1:0]      sp_op;
    logic            var_wr;
    logic            stat_ld;
    logic [ST_W-1:0] stat;
    logic            out_ld;
  } stk_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            lt1;
    logic            lt2;
    logic            lt3;
    logic            full;
    logic            n_neg;
    logic            pick_under;
    logic            out_free;
  } stk_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/stk_dp.sv */
`default_nettype none

module stk_dp import stk_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [OP_W-1:0]         in_req_type,
  input  wire logic signed [VAL_W-1:0] in_push_value,
  input  wire logic [TAG_W-1:0]        in_push_tag,
  input  wire logic [VIDX_W-1:0]       in_var_index,
  input  wire stk_cmd_t                cmd,
  output stk_sts_t                     sts,
  input  wire logic                    out_ready,
  output logic                         out_valid,
  output logic signed [VAL_W-1:0]      out_top_value,
  output logic [TAG_W-1:0]             out_top_tag,
  output logic [PTR_W-1:0]             out_stack_depth,
  output logic [ST_W-1:0]              out_status
);

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] var_r [VAR_COUNT];

  logic [OP_W-1:0]   op_r;
  logic [WORD_W-1:0] pword_r;
  logic [VIDX_W-1:0] vidx_r;
  logic [PTR_W-1:0]  sp_r, sp_nxt;
  logic [WORD_W-1:0] tos_r, tos_nxt;
  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] rdata_r;
  logic [ST_W-1:0]   stat_r;

  logic              out_valid_r;
  logic [VAL_W-1:0]  out_val_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [PTR_W-1:0]  out_depth_r;
  logic [ST_W-1:0]   out_stat_r;

  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] wdata;
  logic [PTR_W-1:0]  addr_full;
  logic [ADDR_W-1:0] addr;
  logic [PTR_W-1:0]  sp_m1;

  assign sp_m1 = sp_r - PTR_W'(1);

  // word pushed by push or load; an out-of-range variable reads as zero
  always_comb begin
    if (op_r == OP_LOAD) begin
      new_word = (vidx_r < VIDX_W'(VAR_COUNT)) ? var_r[vidx_r] : '0;
    end else begin
      new_word = pword_r;
    end
  end

  always_comb begin
    unique case (cmd.addr_sel)
      AS_SP:   addr_full = sp_r;
      AS_SP1:  addr_full = sp_m1;
      AS_SP2:  addr_full = sp_r - PTR_W'(2);
      AS_SP3:  addr_full = sp_r - PTR_W'(3);
      AS_PICK: addr_full = sp_r - PTR_W'(2) - tos_r[PTR_W-1:0];
      default: addr_full = sp_r;
    endcase
  end
  assign addr = addr_full[ADDR_W-1:0];

  always_comb begin
    unique case (cmd.wd_sel)
      WD_NEW:   wdata = new_word;
      WD_TOS:   wdata = tos_r;
      WD_RDATA: wdata = rdata_r;
      default:  wdata = tos_r;
    endcase
  end

  always_comb begin
    unique case (cmd.tos_sel)
      TS_HOLD:  tos_nxt = tos_r;
      TS_NEW:   tos_nxt = new_word;
      TS_RDATA: tos_nxt = rdata_r;
      TS_A:     tos_nxt = a_r;
      default:  tos_nxt = tos_r;
    endcase
  end

  always_comb begin
    unique case (cmd.sp_op)
      SP_HOLD: sp_nxt = sp_r;
      SP_INC:  sp_nxt = sp_r + PTR_W'(1);
      SP_DEC:  sp_nxt = sp_m1;
      default: sp_nxt = sp_r;
    endcase
  end

  // single-ported stack memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_r <= '{default: '0};
    end else if (cmd.var_wr && (vidx_r < VIDX_W'(VAR_COUNT))) begin
      var_r[vidx_r] <= tos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_ld) begin
      op_r    <= in_req_type;
      pword_r <= {in_push_tag, in_push_value};
      vidx_r  <= in_var_index;
    end
    tos_r <= tos_nxt;
    if (cmd.a_ld) begin
      a_r <= rdata_r;
    end
    if (cmd.stat_ld) begin
      stat_r <= cmd.stat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_val_r   <= (sp_r == '0) ? '0 : tos_r[VAL_W-1:0];
      out_tag_r   <= (sp_r == '0) ? '0 : tos_r[WORD_W-1:VAL_W];
      out_depth_r <= sp_r;
      out_stat_r  <= stat_r;
    end
  end

  assign sts.op         = op_r;
  assign sts.lt1        = (sp_r == '0);
  assign sts.lt2        = (sp_r < PTR_W'(2));
  assign sts.lt3        = (sp_r < PTR_W'(3));
  assign sts.full       = (sp_r == PTR_W'(STACK_DEPTH));
  assign sts.n_neg      = tos_r[VAL_W-1];
  // count must lie below the words under it
  assign sts.pick_under = (|tos_r[VAL_W-1:PTR_W]) || (tos_r[PTR_W-1:0] >= sp_m1);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_top_value   = $signed(out_val_r);
  assign out_top_tag     = out_tag_r;
  assign out_stack_depth = out_depth_r;
  assign out_status      = out_stat_r;

`ifndef SYNTH
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= PTR_W'(STACK_DEPTH))
    else $error("stack pointer beyond capacity");

  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sp_op == SP_INC |-> sp_r != PTR_W'(STACK_DEPTH))
    else $error("push on full stack");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sp_op == SP_DEC |-> sp_r != '0)
    else $error("pop on empty stack");

  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || out_ready))
    else $error("result overwrites an untaken word");
`endif

endmodule

`default_nettype wire

/* hw/rtl/stk_ctrl.sv */
`default_nettype none

module stk_ctrl import stk_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire stk_sts_t sts,
  output stk_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_LDTOS = 4'd2;
  localparam logic [3:0] S_SW1   = 4'd3;
  localparam logic [3:0] S_WRTOP = 4'd4;
  localparam logic [3:0] S_RT1   = 4'd5;
  localparam logic [3:0] S_RT2   = 4'd6;
  localparam logic [3:0] S_RT3   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       pk_r, pk_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    pk_nxt    = pk_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_ld = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.stat_ld = 1'b1;
        cmd.stat    = ST_OK;
        pk_nxt      = 1'b0;
        state_nxt   = S_OUT;
        unique case (sts.op)
          OP_PUSH, OP_LOAD: begin
            if (sts.full) begin
              cmd.stat = ST_OVF;
            end else begin
              cmd.mem_wr   = 1'b1;
              cmd.addr_sel = AS_SP;
              cmd.wd_sel   = WD_NEW;
              cmd.tos_sel  = TS_NEW;
              cmd.sp_op    = SP_INC;
            end
          end
          OP_DROP: begin
            if (sts.lt1) begin
              cmd.stat = ST_UNF;
            end else begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = AS_SP2;
              cmd.sp_op    = SP_DEC;
              state_nxt    = S_LDTOS;
            end
          end
          OP_DUP: begin
            if (sts.lt1) begin
              cmd.stat = ST_UNF;
            end else if (sts.full) begin
              cmd.stat = ST_OVF;
            end else begin
              cmd.mem_wr   = 1'b1;
              cmd.addr_sel = AS_SP;
              cmd.wd_sel   = WD_TOS;
              cmd.sp_op    = SP_INC;
            end
          end
          OP_SWAP: begin
            if (sts.lt2) begin
              cmd.stat = ST_UNF;
            end else begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = AS_SP2;
              state_nxt    = S_SW1;
            end
          end
          OP_ROT: begin
            if (sts.lt3) begin
              cmd.stat = ST_UNF;
            end else begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = AS_SP3;
              state_nxt    = S_RT1;
            end
          end
          OP_PICK: begin
            priority if (sts.lt1) begin
              cmd.stat = ST_UNF;
            end else if (sts.n_neg) begin
              // negative count: pop only
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = AS_SP2;
              cmd.sp_op    = SP_DEC;
              state_nxt    = S_LDTOS;
            end else if (sts.pick_under) begin
              cmd.stat = ST_UNF;
            end else begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = AS_PICK;
              pk_nxt       = 1'b1;
              state_nxt    = S_LDTOS;
            end
          end
          OP_STORE: begin
            if (sts.lt1) begin
              cmd.stat = ST_UNF;
            end else begin
              cmd.var_wr = 1'b1;
            end
          end
          default: begin
            cmd.stat = ST_OK;
          end
        endcase
      end
      S_LDTOS: begin
        cmd.tos_sel = TS_RDATA;
        state_nxt   = pk_r ? S_WRTOP : S_OUT;
      end
      S_SW1: begin
        // second word down takes the old top; top takes what was read
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = AS_SP2;
        cmd.wd_sel   = WD_TOS;
        cmd.tos_sel  = TS_RDATA;
        state_nxt    = S_WRTOP;
      end
      S_WRTOP: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = AS_SP1;
        cmd.wd_sel   = WD_TOS;
        state_nxt    = S_OUT;
      end
      S_RT1: begin
        cmd.a_ld     = 1'b1;
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = AS_SP2;
        state_nxt    = S_RT2;
      end
      S_RT2: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = AS_SP3;
        cmd.wd_sel   = WD_RDATA;
        state_nxt    = S_RT3;
      end
      S_RT3: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = AS_SP2;
        cmd.wd_sel   = WD_TOS;
        cmd.tos_sel  = TS_A;
        state_nxt    = S_WRTOP;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pk_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pk_r    <= pk_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/stack_unit_with_pick_and_vars.sv */
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  in       | in_valid / in_ready    | in_req_type, in_push_value, in_push_tag,
//           |                        | in_var_index
//  out      | out_valid / out_ready  | out_top_value, out_top_tag, out_stack_depth,
//           |                        | out_status
//
//  One word in flight at a time. After acceptance the sequencer runs EXEC and OUT
//  for push, dup, load, store and refused requests, with LDTOS between for drop
//  and negative pick, LDTOS and WRTOP for pick, SW1 and WRTOP for swap, and RT1,
//  RT2, RT3 and WRTOP for rotate: accesses to the single-port stack memory. The
//  sequencer then returns to idle. A new word is taken while the previous result
//  still waits in the output register. A stalled result holds the sequencer in its
//  last step. Reset (rst_n low, sync) empties the stack and zeroes all 26 variables at once.
`default_nettype none

module stack_unit_with_pick_and_vars import stk_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [OP_W-1:0]         in_req_type,
  input  wire logic signed [VAL_W-1:0] in_push_value,
  input  wire logic [TAG_W-1:0]        in_push_tag,
  input  wire logic [VIDX_W-1:0]       in_var_index,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [VAL_W-1:0]      out_top_value,
  output logic [TAG_W-1:0]             out_top_tag,
  output logic [PTR_W-1:0]             out_stack_depth,
  output logic [ST_W-1:0]              out_status
);

  stk_cmd_t cmd;
  stk_sts_t sts;

  stk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stk_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req_type     (in_req_type),
    .in_push_value   (in_push_value),
    .in_push_tag     (in_push_tag),
    .in_var_index    (in_var_index),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_top_value   (out_top_value),
    .out_top_tag     (out_top_tag),
    .out_stack_depth (out_stack_depth),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire
